// ----- src/plist_pkg.sv -----
// Package for the positional list engine: field widths, operation and status
// codes, and default sizes. No dependencies.
`default_nettype none
package plist_pkg;

  localparam int unsigned OpW       = 3;
  localparam int unsigned PosW      = 5;
  localparam int unsigned StatW     = 3;
  localparam int unsigned LenW      = 5;
  localparam int unsigned DefCapacity  = 16;
  localparam int unsigned DefDataWidth = 32;

  typedef enum logic [OpW-1:0] {
    OP_INSERT_AT    = 3'd0,
    OP_REMOVE_AT    = 3'd1,
    OP_REMOVE_VALUE = 3'd2,
    OP_UPDATE_AT    = 3'd3,
    OP_UPDATE_VALUE = 3'd4,
    OP_READ_AT      = 3'd5
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  // handshake between the sequencer and the output register
  typedef struct packed {
    logic valid;
  } res_req_t;

  typedef struct packed {
    logic ready;
  } res_ack_t;

endpackage
`default_nettype wire

// ----- src/positional_list_engine_top.sv -----
// Positional list engine, top level: stream ports, field packing and the
// output word register. Depends on plist_pkg, plist_seq and plist_ram.
//
// Usage: one operation word enters on the s_axis side; exactly one result
// word leaves on the m_axis side for each, in order. The list holds up to
// Capacity entries, index 0 at the head.
// An operation is walked through the entry store by a sequencer over one
// read port and one write port. An insert moves the entries from the tail
// down to the position one place towards the tail, then places the value.
// Read and update by position fetch the entry, then return or overwrite it.
// A remove by position fetches the entry, moves every later entry one place
// towards the head and drops the length. Remove and update by value scan the
// slots from the head until a match, then act as by position; failed checks
// and unused codes go straight to the result.
// s_axis_tready is high only while the sequencer is idle. A finished result
// moves into the output register; the next word may be accepted while it
// waits. If the receiver stalls, the sequencer holds its next result until
// the output register frees up.
// Reset clears the length to zero and empties the output register; entry
// contents are not cleared (only slots below the length are ever read).
`default_nettype none
module positional_list_engine_top
  import plist_pkg::*;
#(
  parameter int unsigned Capacity  = DefCapacity,
  parameter int unsigned DataWidth = DefDataWidth,
  localparam int unsigned InW  = ((OpW + PosW + 2 * DataWidth + 7) / 8) * 8,
  localparam int unsigned OutW = ((StatW + DataWidth + LenW + 7) / 8) * 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // op, position, value, new_value (lowest bit up), zero padded
  input  wire logic [InW-1:0]  s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // status, old_value, list_length (lowest bit up), zero padded
  output logic      [OutW-1:0] m_axis_tdata
);

  localparam int unsigned PosLo  = OpW;
  localparam int unsigned ValLo  = PosLo + PosW;
  localparam int unsigned NvalLo = ValLo + DataWidth;
  localparam int unsigned PackW  = StatW + DataWidth + LenW;

  res_req_t             res_req;
  res_ack_t             res_ack;
  logic [StatW-1:0]     res_status;
  logic [DataWidth-1:0] res_old;
  logic [LenW-1:0]      res_len;

  logic                 out_valid_q;
  logic [PackW-1:0]     out_data_q;

  plist_seq #(
    .Capacity (Capacity),
    .DataWidth(DataWidth)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .op_i         (s_axis_tdata[OpW-1:0]),
    .position_i   (s_axis_tdata[ValLo-1:PosLo]),
    .value_i      (s_axis_tdata[NvalLo-1:ValLo]),
    .new_value_i  (s_axis_tdata[NvalLo+DataWidth-1:NvalLo]),
    .res_req_o    (res_req),
    .res_ack_i    (res_ack),
    .status_o     (res_status),
    .old_value_o  (res_old),
    .list_length_o(res_len)
  );

  // take a result whenever the output register is empty or being drained
  assign res_ack.ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ack.ready) begin
      out_valid_q <= res_req.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ack.ready && res_req.valid) begin
      out_data_q <= {res_len, res_old, res_status};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'(out_data_q);

endmodule
`default_nettype wire

// ----- src/plist_ram.sv -----
// Entry store of the positional list engine: one write port and one read
// port with registered read data. Uses nothing from the package.
`default_nettype none
module plist_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ----- src/plist_seq.sv -----
// Sequencer of the positional list engine: checks each operation, then walks
// the entry store one slot at a time to fetch, match and shift entries.
// Depends on plist_pkg and plist_ram.
`default_nettype none
module plist_seq
  import plist_pkg::*;
#(
  parameter int unsigned Capacity  = DefCapacity,
  parameter int unsigned DataWidth = DefDataWidth
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [OpW-1:0]       op_i,
  input  wire logic [PosW-1:0]      position_i,
  input  wire logic [DataWidth-1:0] value_i,
  input  wire logic [DataWidth-1:0] new_value_i,
  output res_req_t                  res_req_o,
  input  wire res_ack_t             res_ack_i,
  output logic [StatW-1:0]          status_o,
  output logic [DataWidth-1:0]      old_value_o,
  output logic [LenW-1:0]           list_length_o
);

  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_SHR_RD = 10'b00_0000_0010,
    S_SHR_WR = 10'b00_0000_0100,
    S_PLACE  = 10'b00_0000_1000,
    S_FETCH  = 10'b00_0001_0000,
    S_EXAM   = 10'b00_0010_0000,
    S_SHL_RD = 10'b00_0100_0000,
    S_SHL_WR = 10'b00_1000_0000,
    S_DROP   = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW-1:0]      ptr_q, ptr_d;
  logic [CntW-1:0]      pos_q, pos_d;
  logic [OpW-1:0]       op_q, op_d;
  logic [DataWidth-1:0] val_q, val_d;
  logic [DataWidth-1:0] nval_q, nval_d;
  logic [DataWidth-1:0] old_q, old_d;
  logic [StatW-1:0]     stat_q, stat_d;

  logic                 mem_we;
  logic [IdxW-1:0]      mem_waddr;
  logic [DataWidth-1:0] mem_wdata;
  logic [IdxW-1:0]      mem_raddr;
  logic [DataWidth-1:0] mem_rdata;

  // shared index unit: one step up, one step down
  logic [CntW-1:0] ptr_inc;
  logic [CntW-1:0] ptr_dec;
  logic [CmpW-1:0] pos_w;
  logic [CmpW-1:0] cnt_w;
  logic            last_slot;

  assign ptr_inc   = ptr_q + CntW'(1);
  assign ptr_dec   = ptr_q - CntW'(1);
  assign pos_w     = CmpW'(position_i);
  assign cnt_w     = CmpW'(count_q);
  assign last_slot = (ptr_inc == count_q);

  plist_ram #(
    .Depth(Capacity),
    .Width(DataWidth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign in_ready_o      = (state_q == S_IDLE);
  assign res_req_o.valid = (state_q == S_DONE);
  assign status_o        = stat_q;
  assign old_value_o     = old_q;
  assign list_length_o   = LenW'(count_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ptr_d     = ptr_q;
    pos_d     = pos_q;
    op_d      = op_q;
    val_d     = val_q;
    nval_d    = nval_q;
    old_d     = old_q;
    stat_d    = stat_q;
    mem_we    = 1'b0;
    mem_waddr = ptr_q[IdxW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = ptr_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = op_i;
          val_d  = value_i;
          nval_d = new_value_i;
          pos_d  = CntW'(position_i);
          old_d  = '0;
          stat_d = ST_OK;
          state_d = S_DONE;
          case (op_i)
            OP_INSERT_AT: begin
              if (pos_w > cnt_w) begin
                stat_d = ST_BADPOS;
              end else if (count_q == CntW'(Capacity)) begin
                stat_d = ST_FULL;
              end else begin
                ptr_d   = count_q;
                state_d = (count_q == CntW'(position_i)) ? S_PLACE : S_SHR_RD;
              end
            end
            OP_REMOVE_AT, OP_UPDATE_AT, OP_READ_AT: begin
              if (count_q == '0) begin
                stat_d = ST_EMPTY;
              end else if (pos_w >= cnt_w) begin
                stat_d = ST_BADPOS;
              end else begin
                ptr_d   = CntW'(position_i);
                state_d = S_FETCH;
              end
            end
            OP_REMOVE_VALUE, OP_UPDATE_VALUE: begin
              if (count_q == '0) begin
                stat_d = ST_EMPTY;
              end else begin
                ptr_d   = '0;
                state_d = S_FETCH;
              end
            end
            default: begin
              // unused codes change nothing
              stat_d = ST_OK;
            end
          endcase
        end
      end
      S_SHR_RD: begin
        mem_raddr = ptr_dec[IdxW-1:0];
        state_d   = S_SHR_WR;
      end
      S_SHR_WR: begin
        // move the word one place towards the tail
        mem_we  = 1'b1;
        ptr_d   = ptr_dec;
        state_d = (ptr_dec == pos_q) ? S_PLACE : S_SHR_RD;
      end
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_wdata = val_q;
        count_d   = count_q + CntW'(1);
        state_d   = S_DONE;
      end
      S_FETCH: begin
        state_d = S_EXAM;
      end
      S_EXAM: begin
        case (op_q)
          OP_READ_AT: begin
            old_d   = mem_rdata;
            state_d = S_DONE;
          end
          OP_UPDATE_AT: begin
            old_d     = mem_rdata;
            mem_we    = 1'b1;
            mem_wdata = nval_q;
            state_d   = S_DONE;
          end
          OP_REMOVE_AT: begin
            old_d   = mem_rdata;
            state_d = last_slot ? S_DROP : S_SHL_RD;
          end
          default: begin
            if (mem_rdata == val_q) begin
              old_d = mem_rdata;
              if (op_q == OP_UPDATE_VALUE) begin
                mem_we    = 1'b1;
                mem_wdata = nval_q;
                state_d   = S_DONE;
              end else begin
                state_d = last_slot ? S_DROP : S_SHL_RD;
              end
            end else if (last_slot) begin
              stat_d  = ST_NOTFOUND;
              state_d = S_DONE;
            end else begin
              ptr_d   = ptr_inc;
              state_d = S_FETCH;
            end
          end
        endcase
      end
      S_SHL_RD: begin
        mem_raddr = ptr_inc[IdxW-1:0];
        state_d   = S_SHL_WR;
      end
      S_SHL_WR: begin
        // close the gap: move the word one place towards the head
        mem_we  = 1'b1;
        ptr_d   = ptr_inc;
        state_d = ((ptr_inc + CntW'(1)) == count_q) ? S_DROP : S_SHL_RD;
      end
      S_DROP: begin
        count_d = count_q - CntW'(1);
        state_d = S_DONE;
      end
      S_DONE: begin
        if (res_ack_i.ready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    op_q   <= op_d;
    val_q  <= val_d;
    nval_q <= nval_d;
    old_q  <= old_d;
    stat_q <= stat_d;
  end

endmodule
`default_nettype wire
